[src/tqs_pkg.sv]
// Shared constants and types for the tone queue sequencer.
package tqs_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FREQ_W = 16;
  localparam int ENTRY_W = 3 * FREQ_W;
  localparam int STEP_W = $clog2(FREQ_W);
  localparam logic [FREQ_W-1:0] DIVIDEND = 16'hffff;
  localparam logic [FREQ_W-1:0] SAT_MAX = 16'hffff;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DECIDE,
    S_DIV,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] on_time;
    logic [FREQ_W-1:0] off_time;
  } entry_t;

endpackage

[src/tqs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/tqs_divider.sv]
// Restoring serial divider that computes 0xffff divided by a 15-bit divisor.
module tqs_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tqs_pkg::FREQ_W-2:0]     divisor,
  output logic                           done,
  output logic [tqs_pkg::FREQ_W-1:0]     quotient
);

  logic                          busy;
  logic [tqs_pkg::STEP_W-1:0]    step;
  logic [tqs_pkg::FREQ_W-2:0]    dvs;
  logic [tqs_pkg::FREQ_W-2:0]    rem;
  logic [tqs_pkg::FREQ_W-1:0]    rem_sh;
  logic                          fits;
  logic [tqs_pkg::FREQ_W-1:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem, quotient[tqs_pkg::FREQ_W-1]};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == tqs_pkg::STEP_W'(tqs_pkg::FREQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= tqs_pkg::DIVIDEND;
    end else if (busy) begin
      rem      <= fits ? rem_sub[tqs_pkg::FREQ_W-2:0] : rem_sh[tqs_pkg::FREQ_W-2:0];
      quotient <= {quotient[tqs_pkg::FREQ_W-2:0], fits};
    end
  end

endmodule

[src/tone_queue_sequencer.sv]
// Top level of the tone queue sequencer: queue control, tick sequencer and output register.
// A push transaction, or a tick on an empty queue, loads its result from S_WRITE.
// Other ticks pass S_FETCH and S_DECIDE first, and S_DIV too when a new compare
// value is computed: the serial divider produces one quotient bit per cycle.
// S_WRITE waits for out_ready while out_valid is high; in_ready is high only while idle.
// Synchronous reset empties the queue and clears the elapsed time and the held tone.
module tone_queue_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] tone_freq,
  input  logic [15:0] on_ms,
  input  logic [15:0] off_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        sounding,
  output logic [15:0] drive_freq,
  output logic [15:0] compare_value,
  output logic [2:0]  queue_count,
  output logic        push_dropped,
  output logic        tone_finished
);

  localparam int D = tqs_pkg::QUEUE_DEPTH;
  localparam int IW = tqs_pkg::IDX_W;
  localparam int CW = tqs_pkg::CNT_W;
  localparam int FW = tqs_pkg::FREQ_W;

  tqs_pkg::state_t state, state_next;

  logic [IW-1:0]  head;
  logic [CW-1:0]  fill;
  logic [FW-1:0]  elapsed;
  logic [FW-1:0]  held_freq;
  logic [FW-1:0]  held_compare;
  logic           dropped;
  logic           finished;

  logic [FW-1:0]  ent_freq;
  logic [FW-1:0]  ent_off;
  logic [FW-1:0]  gap;
  logic           on_phase;

  logic           accept;
  logic           is_full;
  logic           is_empty;
  logic           off_phase;
  logic           freq_zero;
  logic           half_zero;
  logic           ram_we;
  logic           ram_re;
  logic           div_start;
  logic           div_done;
  logic [FW-1:0]  div_quot;
  logic           out_load;

  logic [CW:0]    tail_sum;
  logic [IW-1:0]  tail;
  logic [IW-1:0]  head_inc;
  logic [CW+2:0]  fill_ext;

  tqs_pkg::entry_t wr_entry;
  tqs_pkg::entry_t rd_entry;

  always_comb begin
    accept    = in_valid && in_ready;
    is_full   = fill >= CW'(D);
    is_empty  = fill == '0;
    off_phase = (gap < ent_off) && (elapsed != tqs_pkg::SAT_MAX);
    freq_zero = ent_freq == '0;
    half_zero = ent_freq[FW-1:1] == '0;
    tail_sum  = (CW+1)'(head) + (CW+1)'(fill);
    tail      = (tail_sum >= (CW+1)'(D)) ? IW'(tail_sum - (CW+1)'(D)) : IW'(tail_sum);
    head_inc  = (head == IW'(D - 1)) ? '0 : head + 1'b1;
    fill_ext  = (CW+3)'(fill);
    wr_entry.freq     = tone_freq;
    wr_entry.on_time  = on_ms;
    wr_entry.off_time = off_ms;
  end

  always_comb begin
    state_next = state;
    case (state)
      tqs_pkg::S_IDLE: begin
        if (accept) begin
          if (kind == tqs_pkg::KIND_TICK && !is_empty) begin
            state_next = tqs_pkg::S_FETCH;
          end else begin
            state_next = tqs_pkg::S_WRITE;
          end
        end
      end
      tqs_pkg::S_FETCH: state_next = tqs_pkg::S_DECIDE;
      tqs_pkg::S_DECIDE: begin
        if (on_phase && !freq_zero && !half_zero) begin
          state_next = tqs_pkg::S_DIV;
        end else begin
          state_next = tqs_pkg::S_WRITE;
        end
      end
      tqs_pkg::S_DIV: begin
        if (div_done) begin
          state_next = tqs_pkg::S_WRITE;
        end
      end
      tqs_pkg::S_WRITE: begin
        if (!out_valid || out_ready) begin
          state_next = tqs_pkg::S_IDLE;
        end
      end
      default: state_next = tqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      tqs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ram_we   = accept && kind == tqs_pkg::KIND_PUSH && !is_full;
        ram_re   = accept && kind == tqs_pkg::KIND_TICK;
      end
      tqs_pkg::S_DECIDE: div_start = on_phase && !freq_zero && !half_zero;
      tqs_pkg::S_WRITE:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  tqs_ram #(
    .WIDTH(tqs_pkg::ENTRY_W),
    .DEPTH(D)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(wr_entry),
    .re   (ram_re),
    .raddr(head),
    .rdata(rd_entry)
  );

  tqs_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (ent_freq[FW-1:1]),
    .done    (div_done),
    .quotient(div_quot)
  );

  always_ff @(posedge clk) begin
    if (state == tqs_pkg::S_FETCH) begin
      ent_freq <= rd_entry.freq;
      ent_off  <= rd_entry.off_time;
      gap      <= elapsed - rd_entry.on_time;
      on_phase <= elapsed < rd_entry.on_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      fill         <= '0;
      elapsed      <= '0;
      held_freq    <= '0;
      held_compare <= '0;
      dropped      <= 1'b0;
      finished     <= 1'b0;
    end else begin
      case (state)
        tqs_pkg::S_IDLE: begin
          if (accept) begin
            dropped  <= 1'b0;
            finished <= 1'b0;
            if (kind == tqs_pkg::KIND_PUSH) begin
              if (is_full) begin
                dropped <= 1'b1;
              end else begin
                fill <= fill + 1'b1;
              end
            end else if (is_empty) begin
              held_freq    <= '0;
              held_compare <= '0;
              elapsed      <= '0;
            end
          end
        end
        tqs_pkg::S_DECIDE: begin
          if (on_phase) begin
            held_freq <= ent_freq;
            elapsed   <= elapsed + 1'b1;
            if (freq_zero) begin
              held_compare <= '0;
            end else if (half_zero) begin
              held_compare <= tqs_pkg::SAT_MAX;
            end
          end else if (off_phase) begin
            held_freq    <= '0;
            held_compare <= '0;
            elapsed      <= elapsed + 1'b1;
          end else begin
            head     <= head_inc;
            fill     <= fill - 1'b1;
            elapsed  <= '0;
            finished <= 1'b1;
          end
        end
        tqs_pkg::S_DIV: begin
          if (div_done) begin
            held_compare <= div_quot;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sounding      <= held_freq != '0;
      drive_freq    <= held_freq;
      compare_value <= held_compare;
      queue_count   <= fill_ext[2:0];
      push_dropped  <= dropped;
      tone_finished <= finished;
    end
  end

endmodule
